[src/tmt_pkg.sv]
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, constants and helper functions of the torus mesh tessellator.
// ----------------------------------------------------------------------------
package tmt_pkg;

  localparam int MAX_SEGMENTS     = 1024;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SEG_W            = 11;
  localparam int OFF_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int PH_W             = OFF_W + 2;
  localparam int IDX_W            = OFF_W + 1;
  localparam int ENT_W            = 15;
  localparam int DIR_W            = 16;
  localparam int QUO_W            = 17;
  localparam int NUM_W            = SEG_W + QUO_W;
  localparam int DIV_STAGES       = QUO_W;
  localparam int QDEPTH           = 16;
  localparam int QPTR_W           = $clog2(QDEPTH);
  localparam int VIDX_W           = 22;
  localparam logic [63:0] PI_HALF_Q40 = 64'h1921FB54442;
  localparam int Q14_ONE          = 16384;

  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_CELL   = 1'b1;

  typedef enum logic [2:0] {
    CFG_MAJOR, CFG_TUBE, CFG_CX, CFG_CY, CFG_CZ, CFG_NMAIN, CFG_NTUBE, CFG_ATTR
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_POS, KIND_TEX, KIND_NRM, KIND_TAN, KIND_BIT, KIND_TRI
  } kind_t;

  typedef struct packed {
    logic             cmd;
    logic [SEG_W-1:0] main_step;
    logic [SEG_W-1:0] tube_step;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic               last;
  } out_word_t;

  // One finished item waiting for the result port.
  typedef struct packed {
    logic                    cmd;
    logic                    ok;
    logic signed [31:0]      x;
    logic signed [31:0]      y;
    logic signed [31:0]      z;
    logic [QUO_W-1:0]        u;
    logic [QUO_W-1:0]        v;
    logic signed [DIR_W-1:0] sm;
    logic signed [DIR_W-1:0] cm;
    logic signed [DIR_W-1:0] st;
    logic signed [DIR_W-1:0] ct;
    logic signed [DIR_W-1:0] nx;
    logic signed [DIR_W-1:0] nz;
    logic signed [DIR_W-1:0] bx;
    logic signed [DIR_W-1:0] bz;
    logic [VIDX_W-1:0]       o;
    logic [VIDX_W-1:0]       ow;
  } tmt_entry_t;

  typedef struct packed {
    logic  last;
    kind_t kind;
  } nxt_t;

  typedef logic [ENT_W-1:0] qw_tab_t [0:SINE_TABLE_DEPTH];

  function automatic logic [SEG_W-1:0] lim_seg(input logic [SEG_W-1:0] v);
    logic [SEG_W-1:0] r;
    r = v;
    if (v == '0) r = SEG_W'(1);
    else if (v > SEG_W'(MAX_SEGMENTS)) r = SEG_W'(MAX_SEGMENTS);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

  // Attribute order after a position: texel, normal, tangent, bitangent.
  function automatic nxt_t next_kind(input kind_t cur, input logic [2:0] ae);
    nxt_t r;
    r.last = 1'b1;
    r.kind = KIND_POS;
    case (cur)
      KIND_POS: begin
        if (ae[0]) begin r.last = 1'b0; r.kind = KIND_TEX; end
        else if (ae[1]) begin r.last = 1'b0; r.kind = KIND_NRM; end
        else if (ae[2]) begin r.last = 1'b0; r.kind = KIND_TAN; end
      end
      KIND_TEX: begin
        if (ae[1]) begin r.last = 1'b0; r.kind = KIND_NRM; end
        else if (ae[2]) begin r.last = 1'b0; r.kind = KIND_TAN; end
      end
      KIND_NRM: begin
        if (ae[2]) begin r.last = 1'b0; r.kind = KIND_TAN; end
      end
      KIND_TAN: begin
        r.last = 1'b0;
        r.kind = KIND_BIT;
      end
      default: begin
        r.last = 1'b1;
        r.kind = KIND_POS;
      end
    endcase
    return r;
  endfunction

  // Shift-and-subtract quotient, used only while building the table.
  function automatic logic [63:0] cdiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], a[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter sine wave in Q1.14, Taylor series in Q30, built at elaboration.
  function automatic qw_tab_t build_qw();
    qw_tab_t     t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * PI_HALF_Q40) >> (OFF_W + 10);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = cdiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      r = (sum + 64'd32768) >> 16;
      if (r > 64'(Q14_ONE)) r = 64'(Q14_ONE);
      t[k] = r[ENT_W-1:0];
    end
    return t;
  endfunction

  localparam qw_tab_t QW_TAB = build_qw();

endpackage

[src/tmt_div.sv]
// ----------------------------------------------------------------------------
// tmt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tmt_div import tmt_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [SEG_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [SEG_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] low_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic [SEG_W-1:0] den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [SEG_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [SEG_W-1:0] den_in;
    logic [SEG_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = num[NUM_W-1:QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? SEG_W'(trial - {1'b0, den_in}) : trial[SEG_W-1:0];
      low_r[s] <= {low_in[QUO_W-2:0], 1'b0};
      quo_r[s] <= {quo_in[QUO_W-2:0], ge};
      den_r[s] <= den_in;
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

[src/tmt_emit.sv]
// ----------------------------------------------------------------------------
// tmt_emit
// Item queue and result sequencer: at most one result word per cycle.
// ----------------------------------------------------------------------------
module tmt_emit import tmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  tmt_entry_t wr_entry,
  input  logic [2:0] attr_en,
  output logic       pop,
  output logic       out_strobe,
  output out_word_t  out_word
);

  tmt_entry_t      q_r [QDEPTH];
  logic [QPTR_W:0] wr_ptr_r, rd_ptr_r;
  kind_t           cur_r, cur_nxt;
  logic            strobe_r, strobe_nxt;
  out_word_t       word_r, word_nxt;
  tmt_entry_t      head;
  logic            nonempty;
  nxt_t            nk;

  assign head     = q_r[rd_ptr_r[QPTR_W-1:0]];
  assign nonempty = rd_ptr_r != wr_ptr_r;
  assign nk       = next_kind(cur_r, attr_en);

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_ptr_r[QPTR_W-1:0]] <= wr_entry;
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cur_r    <= KIND_POS;
      strobe_r <= 1'b0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cur_r    <= cur_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    pop              = 1'b0;
    cur_nxt          = cur_r;
    strobe_nxt       = 1'b0;
    word_nxt.kind    = cur_r;
    word_nxt.value_a = head.x;
    word_nxt.value_b = head.y;
    word_nxt.value_c = head.z;
    word_nxt.last    = 1'b0;
    if (nonempty) begin
      if (!head.ok) begin
        // out of the grid: drop silently
        pop = 1'b1;
      end else if (head.cmd == CMD_CELL) begin
        strobe_nxt    = 1'b1;
        word_nxt.kind = KIND_TRI;
        if (cur_r == KIND_TRI) begin
          word_nxt.value_a = 32'(head.ow);
          word_nxt.value_b = 32'(head.o + 1'b1);
          word_nxt.value_c = 32'(head.ow + 1'b1);
          word_nxt.last    = 1'b1;
          pop              = 1'b1;
          cur_nxt          = KIND_POS;
        end else begin
          word_nxt.value_a = 32'(head.o);
          word_nxt.value_b = 32'(head.o + 1'b1);
          word_nxt.value_c = 32'(head.ow);
          cur_nxt          = KIND_TRI;
        end
      end else begin
        strobe_nxt = 1'b1;
        case (cur_r)
          KIND_TEX: begin
            word_nxt.value_a = 32'(head.u);
            word_nxt.value_b = 32'(head.v);
            word_nxt.value_c = '0;
          end
          KIND_NRM: begin
            word_nxt.value_a = 32'(head.nx);
            word_nxt.value_b = 32'(head.st);
            word_nxt.value_c = 32'(head.nz);
          end
          KIND_TAN: begin
            word_nxt.value_a = -(32'(head.sm));
            word_nxt.value_b = '0;
            word_nxt.value_c = 32'(head.cm);
          end
          KIND_BIT: begin
            word_nxt.value_a = 32'(head.bx);
            word_nxt.value_b = 32'(head.ct);
            word_nxt.value_c = 32'(head.bz);
          end
          default: begin
            word_nxt.value_a = head.x;
          end
        endcase
        word_nxt.last = nk.last;
        if (nk.last) begin
          pop     = 1'b1;
          cur_nxt = KIND_POS;
        end else begin
          cur_nxt = nk.kind;
        end
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule

[src/torus_mesh_tessellator.sv]
// ----------------------------------------------------------------------------
// torus_mesh_tessellator
// Torus vertex attributes and grid cell triangles, one grid point or cell per
// command word.
// ----------------------------------------------------------------------------
//
//  channel  ports                          handshake
//  -------  -----------------------------  ----------------------------------
//  input    start, busy, in_word           taken when start & !busy
//  result   out_strobe, out_word           one word per strobe, no back-pressure
//  config   cfg_we, cfg_index, cfg_wdata   written when cfg_we
//
// A command word enters the pipeline in any cycle that busy is low. The first
// result word of an item passes through the input register, 17 divider
// stages, table, sign, product, round and ring stages, queue write and
// output register. Result words leave one per cycle from the single result
// port; a vertex item makes 1 to 5 words, a cell item 2. An item holds a
// credit from acceptance until its last word leaves the queue; with 16
// credits, up to 16 items are in flight at once, and out-of-grid items make
// no word. busy rises when 16 items are in flight; the receiver cannot stall,
// so the pipeline itself never holds. Synchronous reset restores the
// registers to their defaults and empties the pipeline; there is no clearing
// pass.
//
module torus_mesh_tessellator import tmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_strobe,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef struct packed {
    logic             cmd;
    logic             ok;
    logic [SEG_W-1:0] i;
    logic [SEG_W-1:0] j;
  } side_t;

  // ---- configuration registers
  logic [30:0]        major_r, tube_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [SEG_W-1:0]   nmain_r, ntube_r;
  logic [2:0]         attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= 31'd32768;
      tube_r  <= 31'd16384;
      cx_r    <= '0;
      cy_r    <= '0;
      cz_r    <= '0;
      nmain_r <= SEG_W'(32);
      ntube_r <= SEG_W'(32);
      attr_r  <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAJOR: major_r <= cfg_wdata[30:0];
        CFG_TUBE:  tube_r  <= cfg_wdata[30:0];
        CFG_CX:    cx_r    <= cfg_wdata;
        CFG_CY:    cy_r    <= cfg_wdata;
        CFG_CZ:    cz_r    <= cfg_wdata;
        CFG_NMAIN: nmain_r <= cfg_wdata[SEG_W-1:0];
        CFG_NTUBE: ntube_r <= cfg_wdata[SEG_W-1:0];
        default:   attr_r  <= cfg_wdata[2:0];
      endcase
    end
  end

  // Used counts; user holds config static while items are in flight; unchecked.
  logic [SEG_W-1:0] n, nt;
  assign n  = lim_seg(nmain_r);
  assign nt = lim_seg(ntube_r);

  // ---- credits: items accepted and not yet retired by the sequencer
  logic              accept, pop;
  logic [QPTR_W:0]   cnt_r;

  assign accept = start && !busy;
  assign busy   = cnt_r == (QPTR_W + 1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (accept && !pop) cnt_r <= cnt_r + 1'b1;
    else if (!accept && pop) cnt_r <= cnt_r - 1'b1;
  end

  // ---- stage 0: capture the command, build the four dividends
  logic     s0_v_r;
  in_word_t s0_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else s0_v_r <= accept;
    s0_w_r <= in_word;
  end

  logic [SEG_W-1:0] i0, j0;
  logic             ok0;
  logic [NUM_W-1:0] num_pm, num_pt, num_u, num_v;

  assign i0  = s0_w_r.main_step;
  assign j0  = s0_w_r.tube_step;
  assign ok0 = (s0_w_r.cmd == CMD_CELL) ? (i0 < n && j0 < nt) : (i0 <= n && j0 <= nt);

  // phase = floor((a*4*DEPTH + floor(N/2)) / N), texel the same with 65536, u on N-a
  assign num_pm = NUM_W'({i0, PH_W'(0)}) + NUM_W'(n >> 1);
  assign num_pt = NUM_W'({j0, PH_W'(0)}) + NUM_W'(nt >> 1);
  assign num_u  = NUM_W'({SEG_W'(n - i0), (QUO_W - 1)'(0)}) + NUM_W'(n >> 1);
  assign num_v  = NUM_W'({j0, (QUO_W - 1)'(0)}) + NUM_W'(nt >> 1);

  logic [QUO_W-1:0] qm, qt, qu, qv;

  tmt_div u_div_pm (.clk(clk), .num(num_pm), .den(n),  .quo(qm));
  tmt_div u_div_pt (.clk(clk), .num(num_pt), .den(nt), .quo(qt));
  tmt_div u_div_u  (.clk(clk), .num(num_u),  .den(n),  .quo(qu));
  tmt_div u_div_v  (.clk(clk), .num(num_v),  .den(nt), .quo(qv));

  // Side data and valid bits ride alongside the divider stages.
  side_t side_r [DIV_STAGES];
  logic  vld_r  [DIV_STAGES];

  always_ff @(posedge clk) begin
    side_r[0] <= '{cmd: s0_w_r.cmd, ok: ok0, i: i0, j: j0};
    for (int k = 1; k < DIV_STAGES; k++) side_r[k] <= side_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= s0_v_r;
      for (int k = 1; k < DIV_STAGES; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---- stage 1: quarter-wave table lookups
  // sin uses entry(o) in even quadrants, entry(DEPTH-o) in odd ones; cos is
  // one quadrant ahead, so it takes the other entry.
  logic [PH_W-1:0]  pm, pt;
  logic [IDX_W-1:0] im_a, im_b, it_a, it_b;

  assign pm   = qm[PH_W-1:0];
  assign pt   = qt[PH_W-1:0];
  assign im_a = {1'b0, pm[OFF_W-1:0]};
  assign im_b = IDX_W'(SINE_TABLE_DEPTH) - im_a;
  assign it_a = {1'b0, pt[OFF_W-1:0]};
  assign it_b = IDX_W'(SINE_TABLE_DEPTH) - it_a;

  logic             s1_v_r;
  side_t            s1_side_r;
  logic [ENT_W-1:0] s1_esm_r, s1_ecm_r, s1_est_r, s1_ect_r;
  logic             s1_nsm_r, s1_ncm_r, s1_nst_r, s1_nct_r;
  logic [QUO_W-1:0] s1_u_r, s1_v_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= vld_r[DIV_STAGES-1];
    s1_side_r  <= side_r[DIV_STAGES-1];
    s1_esm_r   <= QW_TAB[pm[OFF_W] ? im_b : im_a];
    s1_ecm_r   <= QW_TAB[pm[OFF_W] ? im_a : im_b];
    s1_est_r   <= QW_TAB[pt[OFF_W] ? it_b : it_a];
    s1_ect_r   <= QW_TAB[pt[OFF_W] ? it_a : it_b];
    s1_nsm_r   <= pm[PH_W-1];
    s1_ncm_r   <= pm[PH_W-1] ^ pm[OFF_W];
    s1_nst_r   <= pt[PH_W-1];
    s1_nct_r   <= pt[PH_W-1] ^ pt[OFF_W];
    s1_u_r     <= qu;
    s1_v_val_r <= qv;
  end

  // ---- stage 2: apply quadrant signs
  logic                    s2_v_r;
  side_t                   s2_side_r;
  logic signed [DIR_W-1:0] s2_sm_r, s2_cm_r, s2_st_r, s2_ct_r;
  logic [QUO_W-1:0]        s2_u_r, s2_v_val_r;

  function automatic logic signed [DIR_W-1:0] signed_ent(input logic [ENT_W-1:0] e,
                                                         input logic neg);
    logic signed [DIR_W-1:0] p;
    p = $signed({1'b0, e});
    return neg ? -p : p;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
    s2_side_r  <= s1_side_r;
    s2_sm_r    <= signed_ent(s1_esm_r, s1_nsm_r);
    s2_cm_r    <= signed_ent(s1_ecm_r, s1_ncm_r);
    s2_st_r    <= signed_ent(s1_est_r, s1_nst_r);
    s2_ct_r    <= signed_ent(s1_ect_r, s1_nct_r);
    s2_u_r     <= s1_u_r;
    s2_v_val_r <= s1_v_val_r;
  end

  // ---- stage 3: products and cell vertex offset
  logic                    s3_v_r;
  logic                    s3_cmd_r, s3_ok_r;
  logic signed [47:0]      s3_prc_r, s3_prs_r;
  logic signed [31:0]      s3_nx_r, s3_nz_r, s3_bx_r, s3_bz_r;
  logic signed [DIR_W-1:0] s3_sm_r, s3_cm_r, s3_st_r, s3_ct_r;
  logic [QUO_W-1:0]        s3_u_r, s3_v_val_r;
  logic [VIDX_W-1:0]       s3_o_r, s3_ow_r;
  logic [VIDX_W-1:0]       o_nxt, w_ext;

  assign w_ext = VIDX_W'(nt) + 1'b1;
  assign o_nxt = VIDX_W'(s2_side_r.i) * VIDX_W'(nt) + VIDX_W'(s2_side_r.i)
                 + VIDX_W'(s2_side_r.j);

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
    s3_cmd_r   <= s2_side_r.cmd;
    s3_ok_r    <= s2_side_r.ok;
    s3_prc_r   <= $signed({1'b0, tube_r}) * s2_ct_r;
    s3_prs_r   <= $signed({1'b0, tube_r}) * s2_st_r;
    s3_nx_r    <= s2_cm_r * s2_ct_r;
    s3_nz_r    <= s2_sm_r * s2_ct_r;
    s3_bx_r    <= -(s2_st_r * s2_cm_r);
    s3_bz_r    <= -(s2_st_r * s2_sm_r);
    s3_sm_r    <= s2_sm_r;
    s3_cm_r    <= s2_cm_r;
    s3_st_r    <= s2_st_r;
    s3_ct_r    <= s2_ct_r;
    s3_u_r     <= s2_u_r;
    s3_v_val_r <= s2_v_val_r;
    s3_o_r     <= o_nxt;
    s3_ow_r    <= o_nxt + w_ext;
  end

  // ---- stage 4: round to Q14, ring radius, y
  logic signed [47:0]      rc_sum, rs_sum;
  logic signed [31:0]      nx_sum, nz_sum, bx_sum, bz_sum;
  logic signed [34:0]      ring_nxt;
  logic signed [39:0]      y_sum;

  assign rc_sum   = s3_prc_r + 48'sd8192;
  assign rs_sum   = s3_prs_r + 48'sd8192;
  assign nx_sum   = s3_nx_r + 32'sd8192;
  assign nz_sum   = s3_nz_r + 32'sd8192;
  assign bx_sum   = s3_bx_r + 32'sd8192;
  assign bz_sum   = s3_bz_r + 32'sd8192;
  assign ring_nxt = $signed({4'b0, major_r}) + 35'($signed(rc_sum[47:14]));
  assign y_sum    = 40'($signed(rs_sum[47:14])) + 40'(cy_r);

  logic                    s4_v_r;
  logic                    s4_cmd_r, s4_ok_r;
  logic signed [34:0]      s4_ring_r;
  logic signed [31:0]      s4_y_r;
  logic signed [DIR_W-1:0] s4_nx_r, s4_nz_r, s4_bx_r, s4_bz_r;
  logic signed [DIR_W-1:0] s4_sm_r, s4_cm_r, s4_st_r, s4_ct_r;
  logic [QUO_W-1:0]        s4_u_r, s4_v_val_r;
  logic [VIDX_W-1:0]       s4_o_r, s4_ow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r;
    s4_cmd_r   <= s3_cmd_r;
    s4_ok_r    <= s3_ok_r;
    s4_ring_r  <= ring_nxt;
    s4_y_r     <= sat32(y_sum);
    s4_nx_r    <= nx_sum[29:14];
    s4_nz_r    <= nz_sum[29:14];
    s4_bx_r    <= bx_sum[29:14];
    s4_bz_r    <= bz_sum[29:14];
    s4_sm_r    <= s3_sm_r;
    s4_cm_r    <= s3_cm_r;
    s4_st_r    <= s3_st_r;
    s4_ct_r    <= s3_ct_r;
    s4_u_r     <= s3_u_r;
    s4_v_val_r <= s3_v_val_r;
    s4_o_r     <= s3_o_r;
    s4_ow_r    <= s3_ow_r;
  end

  // ---- stage 5: ring times cos/sin of the main angle
  logic                    s5_v_r;
  logic signed [50:0]      s5_rx_r, s5_rz_r;
  tmt_entry_t              s5_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else s5_v_r <= s4_v_r;
    s5_rx_r   <= s4_ring_r * s4_cm_r;
    s5_rz_r   <= s4_ring_r * s4_sm_r;
    s5_e_r.cmd <= s4_cmd_r;
    s5_e_r.ok  <= s4_ok_r;
    s5_e_r.x   <= '0;
    s5_e_r.y   <= s4_y_r;
    s5_e_r.z   <= '0;
    s5_e_r.u   <= s4_u_r;
    s5_e_r.v   <= s4_v_val_r;
    s5_e_r.sm  <= s4_sm_r;
    s5_e_r.cm  <= s4_cm_r;
    s5_e_r.st  <= s4_st_r;
    s5_e_r.ct  <= s4_ct_r;
    s5_e_r.nx  <= s4_nx_r;
    s5_e_r.nz  <= s4_nz_r;
    s5_e_r.bx  <= s4_bx_r;
    s5_e_r.bz  <= s4_bz_r;
    s5_e_r.o   <= s4_o_r;
    s5_e_r.ow  <= s4_ow_r;
  end

  // ---- round, add the centre, saturate; write into the queue
  logic signed [50:0] rx_sum, rz_sum;
  tmt_entry_t         wr_entry;

  assign rx_sum = s5_rx_r + 51'sd8192;
  assign rz_sum = s5_rz_r + 51'sd8192;

  always_comb begin
    wr_entry   = s5_e_r;
    wr_entry.x = sat32(40'($signed(rx_sum[50:14])) + 40'(cx_r));
    wr_entry.z = sat32(40'($signed(rz_sum[50:14])) + 40'(cz_r));
  end

  tmt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (s5_v_r),
    .wr_entry  (wr_entry),
    .attr_en   (attr_r),
    .pop       (pop),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

endmodule

[src/tmt_checker.sv]
// ----------------------------------------------------------------------------
// tmt_checker
// Port-level checks of the tessellator's result sequence.
// ----------------------------------------------------------------------------
module tmt_checker import tmt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input out_word_t   out_word
);

  // drop the strobe during reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // busy only rises right after a word was taken
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted word");

  // the first triangle of a cell is followed at once by the second
  a_tri_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.kind == KIND_TRI && !out_word.last
    |=> out_strobe && out_word.kind == KIND_TRI && out_word.last)
    else $error("cell triangle pair broken");

  // second triangle shares the edge of the first
  a_tri_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.kind == KIND_TRI && out_word.last
    |-> out_word.value_a == $past(out_word.value_c)
        && out_word.value_b == $past(out_word.value_b))
    else $error("triangle pair does not share an edge");

  // tangent is always followed by bitangent
  a_tan_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.kind == KIND_TAN
    |=> out_strobe && out_word.kind == KIND_BIT && out_word.last)
    else $error("tangent not followed by bitangent");

endmodule

bind torus_mesh_tessellator tmt_checker u_tmt_checker (.*);
